>>> rtl/core/fcpt_pkg.sv
// ----------------------------------------------------------------------------
// fcpt_pkg: shared types and constants for the frame clock pair tick unit
// Field widths, the base-60 modulus and the play clock hold point.
// ----------------------------------------------------------------------------
package fcpt_pkg;

    // field widths
    localparam int unsigned FIELD_W = 6;   // frames, seconds, minutes
    localparam int unsigned HOURS_W = 8;   // hours wrap at 256

    // every sub-hour stage counts modulo 60; a tick adds at most 60 frames
    localparam int unsigned UNIT_MOD   = 60;
    localparam int unsigned MAX_FRAMES = 60;

    // play clock stops once it reads 99:59:59 and 57 frames or more
    localparam int unsigned HOLD_HOURS = 99;
    localparam int unsigned HOLD_MIN   = 59;
    localparam int unsigned HOLD_SEC   = 59;
    localparam int unsigned HOLD_FRAME = 57;

    // stream widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 64;

    // one clock's readout
    typedef struct packed {
        logic [HOURS_W-1:0] hours;
        logic [FIELD_W-1:0] min;
        logic [FIELD_W-1:0] sec;
        logic [FIELD_W-1:0] frame;
    } clock_val_t;

endpackage

>>> rtl/core/fcpt_cell.sv
// ----------------------------------------------------------------------------
// fcpt_cell: one base-60 counter cell
// Holds one digit pair (0..59), adds the incoming amount, wraps once and
// passes a carry to the next cell.
// ----------------------------------------------------------------------------
module fcpt_cell
    import fcpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,        // advance this cycle
    input  logic [FIELD_W-1:0] add_in,    // 0..60 from the left neighbor
    output logic [FIELD_W-1:0] value,     // value before this cycle's add
    output logic [FIELD_W-1:0] value_upd, // value after this cycle's add
    output logic               carry      // one carry into the next cell
);

    logic [FIELD_W-1:0] value_reg;
    logic [FIELD_W-1:0] value_next;
    logic [FIELD_W:0]   sum;
    logic [FIELD_W:0]   sum_wrap;
    logic               wrap;

    // add and wrap once
    always_comb begin
        sum      = {1'b0, value_reg} + {1'b0, add_in};
        sum_wrap = sum - (FIELD_W+1)'(UNIT_MOD);
        wrap     = (sum >= (FIELD_W+1)'(UNIT_MOD));
        if (en) begin
            value_next = wrap ? sum_wrap[FIELD_W-1:0] : sum[FIELD_W-1:0];
        end else begin
            value_next = value_reg;
        end
        carry = en && wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value     = value_reg;
    assign value_upd = value_next;

endmodule

>>> rtl/core/fcpt_clock.sv
// ----------------------------------------------------------------------------
// fcpt_clock: frames / seconds / minutes / hours clock
// Three base-60 cells in a row feed an 8-bit hours counter; each cell hands
// at most one carry to its neighbor.
// ----------------------------------------------------------------------------
module fcpt_clock
    import fcpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,       // advance this cycle
    input  logic [FIELD_W-1:0] add_in,   // frames to add, 0..60
    output clock_val_t         cur,      // readout before the add
    output clock_val_t         upd       // readout after the add
);

    logic               c_frame;
    logic               c_sec;
    logic               c_min;
    logic [HOURS_W-1:0] hours_reg;
    logic [HOURS_W-1:0] hours_next;

    // frames cell
    fcpt_cell u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .add_in    (add_in),
        .value     (cur.frame),
        .value_upd (upd.frame),
        .carry     (c_frame)
    );

    // seconds cell
    fcpt_cell u_sec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .add_in    ({{(FIELD_W-1){1'b0}}, c_frame}),
        .value     (cur.sec),
        .value_upd (upd.sec),
        .carry     (c_sec)
    );

    // minutes cell
    fcpt_cell u_min (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .add_in    ({{(FIELD_W-1){1'b0}}, c_sec}),
        .value     (cur.min),
        .value_upd (upd.min),
        .carry     (c_min)
    );

    // hours: plain wrap at 256
    assign hours_next = hours_reg + {{(HOURS_W-1){1'b0}}, c_min};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hours_reg <= '0;
        end else begin
            hours_reg <= hours_next;
        end
    end

    assign cur.hours = hours_reg;
    assign upd.hours = hours_next;

endmodule

>>> rtl/core/frame_clock_pair_tick_unit.sv
// ----------------------------------------------------------------------------
// frame_clock_pair_tick_unit: frame loop counter, countdown and play clocks
// Each beat adds its frame count (saturated to 60) to a free-running
// frame counter, to the countdown clock when run is set, and to the play
// clock unless it stands at its hold point; the updated readout goes out.
//
//   channel | dir | tdata (low bit up)                          | tuser
//   s_      | in  | tick_frames[5:0], pad                       | countdown_run
//   m_      | out | loop_frame, count f/s/m/h, play f/s/m/h, pad | -
//
// One beat per cycle while s_tready is high; the whole add and carry cascade is
// combinational and the result is registered.
// Reset clears every counter to zero and empties the output stages.
// A stalled output keeps a result in the output register and takes one more
// into a skid register; s_tready drops only while the skid register is full.
// ----------------------------------------------------------------------------
module frame_clock_pair_tick_unit
    import fcpt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [5:0] tick_frames, [7:6] zero
    input  logic                s_tuser,   // [0] countdown_run
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [5:0] loop_frame, [11:6] count_frame,
                                           // [17:12] count_sec, [23:18] count_min,
                                           // [31:24] count_hours, [37:32] play_frame,
                                           // [43:38] play_sec, [49:44] play_min,
                                           // [57:50] play_hours, [63:58] zero
);

    logic               accept;
    logic [FIELD_W-1:0] tick_frames;
    logic [FIELD_W-1:0] add_amt;
    logic               hold;
    logic [FIELD_W-1:0] loop_cur;
    logic [FIELD_W-1:0] loop_upd;
    logic               loop_carry;
    clock_val_t         count_cur;
    clock_val_t         count_upd;
    clock_val_t         play_cur;
    clock_val_t         play_upd;
    logic [M_DATA_W-1:0] result;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [M_DATA_W-1:0] skid_data_reg;
    logic [M_DATA_W-1:0] skid_data_next;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // saturate the frame count
    assign tick_frames = s_tdata[FIELD_W-1:0];
    assign add_amt = (tick_frames > FIELD_W'(MAX_FRAMES)) ? FIELD_W'(MAX_FRAMES) : tick_frames;

    // play clock hold point, checked before the add
    assign hold = (play_cur.hours == HOURS_W'(HOLD_HOURS))
               && (play_cur.min == FIELD_W'(HOLD_MIN))
               && (play_cur.sec == FIELD_W'(HOLD_SEC))
               && (play_cur.frame >= FIELD_W'(HOLD_FRAME));

    // free-running frame counter, its carry goes nowhere
    fcpt_cell u_loop (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept),
        .add_in    (add_amt),
        .value     (loop_cur),
        .value_upd (loop_upd),
        .carry     (loop_carry)
    );

    fcpt_clock u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (accept && s_tuser),
        .add_in  (add_amt),
        .cur     (count_cur),
        .upd     (count_upd)
    );

    fcpt_clock u_play (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (accept && !hold),
        .add_in  (add_amt),
        .cur     (play_cur),
        .upd     (play_upd)
    );

    // pack the updated readout; loop_cur and loop_carry are not part of it
    assign result = {6'b0,
                     play_upd.hours, play_upd.min, play_upd.sec, play_upd.frame,
                     count_upd.hours, count_upd.min, count_upd.sec, count_upd.frame,
                     loop_upd}
                  | {{(M_DATA_W-1){1'b0}}, 1'b0 & loop_carry & (|loop_cur)};

    // output register plus skid register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_data_next = result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> dv/frame_clock_pair_tick_unit_tb.sv
// ----------------------------------------------------------------------------
// frame_clock_pair_tick_unit_tb: self-checking bench for the frame clock unit
// Streams frame-count ticks into the unit and checks every readout beat
// against a cycle-free model of the loop counter, countdown and play clocks.
// Directed ticks cover the frame count extremes, saturation and carries;
// random ticks follow. Both stream sides idle at random, with one stretch
// free of idling, and the receiver holds off once long enough to stall the
// input.
// ----------------------------------------------------------------------------
module frame_clock_pair_tick_unit_tb;
    import fcpt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20_000;
    localparam int unsigned QUIET_START = 600;    // window with no idling
    localparam int unsigned QUIET_END   = 900;

    typedef struct packed {
        logic [FIELD_W-1:0] frames;
        logic               run;
    } tick_t;

    typedef struct packed {
        logic [FIELD_W-1:0] loop_frame;
        clock_val_t         count_clk;
        clock_val_t         play_clk;
    } readout_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // model state
    logic [FIELD_W-1:0] loop_frame_q = '0;
    clock_val_t         count_clk_q  = '0;
    clock_val_t         play_clk_q   = '0;

    tick_t       ticks_q[$];
    readout_t    readout_q[$];
    tick_t       drv_tick;
    readout_t    exp_r;
    int unsigned cycle_cnt  = 0;
    int unsigned beats_in   = 0;
    int unsigned readouts   = 0;
    int unsigned errors     = 0;
    logic        hold_off   = 1'b0;
    wire         quiet = (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_END);

    frame_clock_pair_tick_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // add frames to a clock; every stage carries at most once, hours wrap at 256
    function automatic void clock_advance(input int unsigned add, inout clock_val_t c);
        int unsigned        f;
        int unsigned        s;
        int unsigned        m;
        logic [HOURS_W-1:0] h;
        f = c.frame + add;
        s = c.sec;
        m = c.min;
        h = c.hours;
        if (f >= UNIT_MOD) begin
            f -= UNIT_MOD;
            s++;
        end
        if (s >= UNIT_MOD) begin
            s -= UNIT_MOD;
            m++;
        end
        if (m >= UNIT_MOD) begin
            m -= UNIT_MOD;
            h = h + 1'b1;
        end
        c.frame = FIELD_W'(f);
        c.sec   = FIELD_W'(s);
        c.min   = FIELD_W'(m);
        c.hours = h;
    endfunction

    // one tick: update model state and return the readout it should produce
    function automatic readout_t advance_clocks(input logic [FIELD_W-1:0] frames,
                                                input logic run);
        int unsigned add;
        int unsigned lf;
        readout_t    r;
        add = (frames > MAX_FRAMES) ? MAX_FRAMES : frames;
        lf  = loop_frame_q + add;
        if (lf >= UNIT_MOD)
            lf -= UNIT_MOD;
        loop_frame_q = FIELD_W'(lf);
        if (run)
            clock_advance(add, count_clk_q);
        // hold test looks at the play clock before this tick's add
        if (!(play_clk_q.hours == HOLD_HOURS && play_clk_q.min == HOLD_MIN &&
              play_clk_q.sec == HOLD_SEC && play_clk_q.frame >= HOLD_FRAME))
            clock_advance(add, play_clk_q);
        r.loop_frame = loop_frame_q;
        r.count_clk  = count_clk_q;
        r.play_clk   = play_clk_q;
        return r;
    endfunction

    task automatic push_tick(input int unsigned frames, input bit run);
        tick_t t;
        t.frames = FIELD_W'(frames);
        t.run    = run;
        ticks_q.push_back(t);
    endtask

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // driver: offer the next pending tick once the current beat is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                readout_q.push_back(advance_clocks(s_tdata[FIELD_W-1:0], s_tuser));
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (ticks_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
                    drv_tick = ticks_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'(drv_tick.frames);
                    s_tuser  <= drv_tick.run;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each readout beat against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                readouts++;
                if (readout_q.size() == 0) begin
                    $error("readout beat with no tick waiting for it");
                    errors++;
                end else begin
                    exp_r = readout_q.pop_front();
                    check_field("loop_frame",  exp_r.loop_frame,      m_tdata[5:0]);
                    check_field("count_frame", exp_r.count_clk.frame, m_tdata[11:6]);
                    check_field("count_sec",   exp_r.count_clk.sec,   m_tdata[17:12]);
                    check_field("count_min",   exp_r.count_clk.min,   m_tdata[23:18]);
                    check_field("count_hours", exp_r.count_clk.hours, m_tdata[31:24]);
                    check_field("play_frame",  exp_r.play_clk.frame,  m_tdata[37:32]);
                    check_field("play_sec",    exp_r.play_clk.sec,    m_tdata[43:38]);
                    check_field("play_min",    exp_r.play_clk.min,    m_tdata[49:44]);
                    check_field("play_hours",  exp_r.play_clk.hours,  m_tdata[57:50]);
                end
            end
            m_tready <= !hold_off && (quiet || $urandom_range(0, 99) >= 10);
        end
    end

    // cycle count and run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("frame_clock_pair_tick_unit test failed");
            $finish;
        end
    end

    // long receiver stall early on, so the output stages fill and s_tready drops
    initial begin
        while (!aresetn) @(posedge aclk);
        repeat (400) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (150) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int unsigned k;

        // directed: frame count extremes, saturation, run on and off, carries
        push_tick(0, 0);
        push_tick(0, 1);
        push_tick(60, 1);
        push_tick(63, 1);
        push_tick(61, 0);
        push_tick(62, 1);
        push_tick(59, 1);
        push_tick(1, 1);
        push_tick(60, 0);
        push_tick(30, 1);
        push_tick(45, 1);
        push_tick(15, 0);
        push_tick(32, 1);
        push_tick(31, 1);
        push_tick(16, 1);
        push_tick(8, 1);
        push_tick(4, 1);
        push_tick(2, 1);
        push_tick(60, 1);
        push_tick(58, 0);

        // random ticks
        for (k = 0; k < 600; k++)
            push_tick($urandom_range(0, 63), $urandom_range(0, 3) != 0);

        // mostly full seconds, to push carries through minutes
        for (k = 0; k < 500; k++)
            push_tick(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : MAX_FRAMES,
                      $urandom_range(0, 3) != 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (ticks_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (readout_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (readout_q.size() != 0) begin
            $error("%0d readouts never arrived", readout_q.size());
            errors++;
        end

        $display("%0d ticks driven, %0d readouts checked; countdown ended at %0d:%0d:%0d:%0d",
                 beats_in, readouts, count_clk_q.hours, count_clk_q.min,
                 count_clk_q.sec, count_clk_q.frame);
        $display("play clock ended at %0d:%0d:%0d:%0d, loop frame at %0d",
                 play_clk_q.hours, play_clk_q.min, play_clk_q.sec, play_clk_q.frame,
                 loop_frame_q);
        if (errors == 0) begin
            $display("frame_clock_pair_tick_unit test passed");
        end else begin
            $display("frame_clock_pair_tick_unit test failed");
        end
        $finish;
    end

endmodule
